// ===== hw/rtl/jsu_pkg.sv =====
// Shared types, character codes and UTF-8 helpers for the JSON string unescaper.
// Used by jsu_decode, jsu_out_queue and json_string_unescape_utf8. No dependencies.
package jsu_pkg;

	// Decoder phase codes; code 7 is unused and decodes as normal text
	typedef enum logic [2:0] {
		PH_NORMAL      = 3'd0,
		PH_ESC         = 3'd1,
		PH_HEX         = 3'd2,
		PH_AFTER_HI    = 3'd3,
		PH_AFTER_HI_BS = 3'd4,
		PH_LOW_HEX     = 3'd5,
		PH_DONE        = 3'd6
	} phase_t;

	// Result bytes per input item and derived widths
	localparam int MAX_OUT = 9;
	localparam int CNT_W   = $clog2(MAX_OUT + 1);
	localparam int IDX_W   = $clog2(MAX_OUT);

	// Pieces appended into a result group: at most five bytes
	localparam int PIECE_N     = 5;
	localparam int PIECE_LEN_W = $clog2(PIECE_N + 1);

	// Depth of the result group queue
	localparam int GRP_DEPTH = 2;
	localparam int GRP_PTR_W = (GRP_DEPTH > 1) ? $clog2(GRP_DEPTH) : 1;
	localparam int GRP_CNT_W = $clog2(GRP_DEPTH + 1);

	// Code point constants
	localparam logic [15:0] SURR_HI_MIN = 16'hD800;
	localparam logic [15:0] SURR_HI_MAX = 16'hDBFF;
	localparam logic [15:0] SURR_LO_MIN = 16'hDC00;
	localparam logic [15:0] SURR_LO_MAX = 16'hDFFF;
	localparam logic [20:0] REPL_CP     = 21'h00FFFD;
	localparam logic [20:0] SUPP_BASE   = 21'h010000;

	// UTF-8 marker bits
	localparam logic [7:0] UTF8_LEAD2 = 8'hC0;
	localparam logic [7:0] UTF8_LEAD3 = 8'hE0;
	localparam logic [7:0] UTF8_LEAD4 = 8'hF0;
	localparam logic [7:0] UTF8_CONT  = 8'h80;
	localparam logic [7:0] UTF8_MASK  = 8'h3F;

	// Characters
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_LB     = 8'h62;
	localparam logic [7:0] CH_LF     = 8'h66;
	localparam logic [7:0] CH_LN     = 8'h6E;
	localparam logic [7:0] CH_LR     = 8'h72;
	localparam logic [7:0] CH_LT     = 8'h74;
	localparam logic [7:0] CH_LU     = 8'h75;
	localparam logic [7:0] CH_0      = 8'h30;
	localparam logic [7:0] CH_9      = 8'h39;
	localparam logic [7:0] CH_LA     = 8'h61;
	localparam logic [7:0] CH_UA     = 8'h41;
	localparam logic [7:0] CH_UF     = 8'h46;
	localparam logic [7:0] CTL_BS    = 8'h08;
	localparam logic [7:0] CTL_FF    = 8'h0C;
	localparam logic [7:0] CTL_LF    = 8'h0A;
	localparam logic [7:0] CTL_CR    = 8'h0D;
	localparam logic [7:0] CTL_TAB   = 8'h09;

	typedef logic [MAX_OUT-1:0][7:0] obuf_t;
	typedef logic [PIECE_N-1:0][7:0] piece_bytes_t;

	typedef struct packed {
		piece_bytes_t           bytes;
		logic [PIECE_LEN_W-1:0] len;
	} piece_t;

	typedef struct packed {
		obuf_t            bytes;
		logic [CNT_W-1:0] count;
	} acc_t;

	// Decoder state
	typedef struct packed {
		phase_t      phase;
		logic [15:0] hex_value;
		logic [2:0]  digit_count;
		logic [23:0] digit_history;
		logic [15:0] high_surrogate;
	} dec_state_t;

	localparam dec_state_t DEC_RESET = '{PH_NORMAL, 16'h0, 3'h0, 24'h0, 16'h0};

	// All results of one input item
	typedef struct packed {
		obuf_t            bytes;
		logic [CNT_W-1:0] count;
		logic             finish;
		logic             closed;
	} group_t;

	// Return {valid, value} for an ASCII hex digit
	function automatic logic [4:0] hex_digit(input logic [7:0] c);
		logic [7:0] t;
		t = c - CH_0;
		if (c >= CH_0 && c <= CH_9) begin
			return {1'b1, t[3:0]};
		end
		if (c >= CH_LA && c <= CH_LF) begin
			t = c - CH_LA + 8'd10;
			return {1'b1, t[3:0]};
		end
		if (c >= CH_UA && c <= CH_UF) begin
			t = c - CH_UA + 8'd10;
			return {1'b1, t[3:0]};
		end
		return 5'h00;
	endfunction

	// Piece of a single byte
	function automatic piece_t one_piece(input logic [7:0] b0);
		piece_t p;
		p.bytes = '0;
		p.bytes[0] = b0;
		p.len = PIECE_LEN_W'(1);
		return p;
	endfunction

	// Piece of two bytes
	function automatic piece_t two_piece(input logic [7:0] b0, input logic [7:0] b1);
		piece_t p;
		p.bytes = '0;
		p.bytes[0] = b0;
		p.bytes[1] = b1;
		p.len = PIECE_LEN_W'(2);
		return p;
	endfunction

	// UTF-8 encoding of a code point
	function automatic piece_t utf8_piece(input logic [20:0] cp);
		piece_t p;
		p.bytes = '0;
		if (cp < 21'h80) begin
			p.bytes[0] = {1'b0, cp[6:0]};
			p.len = PIECE_LEN_W'(1);
		end else if (cp < 21'h800) begin
			p.bytes[0] = UTF8_LEAD2 | {3'b000, cp[10:6]};
			p.bytes[1] = UTF8_CONT | ({2'b00, cp[5:0]} & UTF8_MASK);
			p.len = PIECE_LEN_W'(2);
		end else if (cp < SUPP_BASE) begin
			p.bytes[0] = UTF8_LEAD3 | {4'h0, cp[15:12]};
			p.bytes[1] = UTF8_CONT | ({2'b00, cp[11:6]} & UTF8_MASK);
			p.bytes[2] = UTF8_CONT | ({2'b00, cp[5:0]} & UTF8_MASK);
			p.len = PIECE_LEN_W'(3);
		end else begin
			p.bytes[0] = UTF8_LEAD4 | {5'h00, cp[20:18]};
			p.bytes[1] = UTF8_CONT | ({2'b00, cp[17:12]} & UTF8_MASK);
			p.bytes[2] = UTF8_CONT | ({2'b00, cp[11:6]} & UTF8_MASK);
			p.bytes[3] = UTF8_CONT | ({2'b00, cp[5:0]} & UTF8_MASK);
			p.len = PIECE_LEN_W'(4);
		end
		return p;
	endfunction

	// Literal backslash, 'u' and up to three stored digits
	function automatic piece_t literal_piece(input logic [2:0] cnt, input logic [23:0] hist);
		piece_t     p;
		logic [1:0] n;
		n = (cnt > 3'd3) ? 2'd3 : cnt[1:0];
		p.bytes[0] = CH_BSLASH;
		p.bytes[1] = CH_LU;
		p.bytes[2] = hist[7:0];
		p.bytes[3] = hist[15:8];
		p.bytes[4] = hist[23:16];
		p.len = PIECE_LEN_W'(2) + PIECE_LEN_W'(n);
		return p;
	endfunction

	// Append a piece behind the bytes already collected, dropping overflow
	function automatic acc_t append(input acc_t a, input piece_t p);
		acc_t           r;
		logic [CNT_W:0] sum;
		r = a;
		for (int i = 0; i < MAX_OUT; i++) begin
			for (int k = 0; k < PIECE_N; k++) begin
				if (k < int'(p.len) && int'(a.count) + k == i) begin
					r.bytes[i] = p.bytes[k];
				end
			end
		end
		sum = {1'b0, a.count} + (CNT_W + 1)'(p.len);
		if (sum > (CNT_W + 1)'(MAX_OUT)) begin
			r.count = CNT_W'(MAX_OUT);
		end else begin
			r.count = sum[CNT_W-1:0];
		end
		return r;
	endfunction

endpackage

// ===== hw/rtl/jsu_decode.sv =====
// Combinational decoder: one raw byte plus the current state gives the next
// state and the group of result bytes. Depends on jsu_pkg.
module jsu_decode (
	input  jsu_pkg::dec_state_t cur,
	input  logic [7:0]          data,
	input  logic                msg_end,
	output jsu_pkg::dec_state_t nxt,
	output jsu_pkg::group_t     grp,
	output logic                emit
);

	typedef enum logic [2:0] {
		TAIL_NONE,
		TAIL_TEXT,
		TAIL_ESC,
		TAIL_FIRST,
		TAIL_CP
	} tail_t;

	tail_t         tail;
	logic          repl_pre;
	logic          lit_pre;
	logic [20:0]   tail_cp;
	logic [4:0]    hd;
	logic [15:0]   new_hex;
	logic          closed_now;
	logic          finish;
	jsu_pkg::acc_t acc;

	assign hd      = jsu_pkg::hex_digit(data);
	assign new_hex = {cur.hex_value[11:0], hd[3:0]};

	always_comb begin
		nxt        = cur;
		tail       = TAIL_NONE;
		repl_pre   = 1'b0;
		lit_pre    = 1'b0;
		tail_cp    = jsu_pkg::REPL_CP;
		closed_now = 1'b0;
		finish     = 1'b0;
		acc        = '0;

		// Choose the prefix and the closing action for the current phase
		unique case (cur.phase)
			jsu_pkg::PH_ESC: begin
				tail = TAIL_ESC;
			end
			jsu_pkg::PH_HEX, jsu_pkg::PH_LOW_HEX: begin
				if (hd[4]) begin
					unique case (cur.digit_count)
						3'd0: nxt.digit_history[7:0] = data;
						3'd1: nxt.digit_history[15:8] = data;
						3'd2: nxt.digit_history[23:16] = data;
						default: ;
					endcase
					nxt.hex_value   = new_hex;
					nxt.digit_count = cur.digit_count + 3'd1;
					if (cur.digit_count == 3'd3) begin
						if (cur.phase == jsu_pkg::PH_HEX) begin
							tail = TAIL_FIRST;
						end else if (new_hex >= jsu_pkg::SURR_LO_MIN &&
							new_hex <= jsu_pkg::SURR_LO_MAX) begin
							tail    = TAIL_CP;
							tail_cp = jsu_pkg::SUPP_BASE +
								{1'b0, cur.high_surrogate[9:0], new_hex[9:0]};
						end else begin
							repl_pre = 1'b1;
							tail     = TAIL_FIRST;
						end
					end
				end else begin
					repl_pre = (cur.phase == jsu_pkg::PH_LOW_HEX);
					lit_pre  = 1'b1;
					tail     = TAIL_TEXT;
				end
			end
			jsu_pkg::PH_AFTER_HI: begin
				if (data == jsu_pkg::CH_BSLASH) begin
					nxt.phase = jsu_pkg::PH_AFTER_HI_BS;
				end else begin
					repl_pre = 1'b1;
					tail     = TAIL_TEXT;
				end
			end
			jsu_pkg::PH_AFTER_HI_BS: begin
				if (data == jsu_pkg::CH_LU) begin
					nxt.phase         = jsu_pkg::PH_LOW_HEX;
					nxt.hex_value     = '0;
					nxt.digit_count   = '0;
					nxt.digit_history = '0;
				end else begin
					repl_pre = 1'b1;
					tail     = TAIL_ESC;
				end
			end
			jsu_pkg::PH_DONE: begin
				tail = TAIL_NONE;
			end
			default: begin
				tail = TAIL_TEXT;
			end
		endcase

		// Emit prefixes in order
		if (repl_pre) begin
			acc = jsu_pkg::append(acc, jsu_pkg::utf8_piece(jsu_pkg::REPL_CP));
		end
		if (lit_pre) begin
			acc = jsu_pkg::append(acc,
				jsu_pkg::literal_piece(cur.digit_count, cur.digit_history));
		end

		// Apply the closing action
		unique case (tail)
			TAIL_TEXT: begin
				nxt.phase = jsu_pkg::PH_NORMAL;
				if (data == jsu_pkg::CH_QUOTE) begin
					nxt.phase  = jsu_pkg::PH_DONE;
					closed_now = 1'b1;
				end else if (data == jsu_pkg::CH_BSLASH) begin
					nxt.phase = jsu_pkg::PH_ESC;
				end else begin
					acc = jsu_pkg::append(acc, jsu_pkg::one_piece(data));
				end
			end
			TAIL_ESC: begin
				nxt.phase = jsu_pkg::PH_NORMAL;
				unique case (data)
					jsu_pkg::CH_QUOTE:
						acc = jsu_pkg::append(acc, jsu_pkg::one_piece(jsu_pkg::CH_QUOTE));
					jsu_pkg::CH_BSLASH:
						acc = jsu_pkg::append(acc, jsu_pkg::one_piece(jsu_pkg::CH_BSLASH));
					jsu_pkg::CH_SLASH:
						acc = jsu_pkg::append(acc, jsu_pkg::one_piece(jsu_pkg::CH_SLASH));
					jsu_pkg::CH_LB:
						acc = jsu_pkg::append(acc, jsu_pkg::one_piece(jsu_pkg::CTL_BS));
					jsu_pkg::CH_LF:
						acc = jsu_pkg::append(acc, jsu_pkg::one_piece(jsu_pkg::CTL_FF));
					jsu_pkg::CH_LN:
						acc = jsu_pkg::append(acc, jsu_pkg::one_piece(jsu_pkg::CTL_LF));
					jsu_pkg::CH_LR:
						acc = jsu_pkg::append(acc, jsu_pkg::one_piece(jsu_pkg::CTL_CR));
					jsu_pkg::CH_LT:
						acc = jsu_pkg::append(acc, jsu_pkg::one_piece(jsu_pkg::CTL_TAB));
					jsu_pkg::CH_LU: begin
						nxt.phase         = jsu_pkg::PH_HEX;
						nxt.hex_value     = '0;
						nxt.digit_count   = '0;
						nxt.digit_history = '0;
					end
					default:
						acc = jsu_pkg::append(acc,
							jsu_pkg::two_piece(jsu_pkg::CH_BSLASH, data));
				endcase
			end
			TAIL_FIRST: begin
				if (new_hex >= jsu_pkg::SURR_HI_MIN && new_hex <= jsu_pkg::SURR_HI_MAX) begin
					nxt.high_surrogate = new_hex;
					nxt.phase          = jsu_pkg::PH_AFTER_HI;
				end else begin
					nxt.phase = jsu_pkg::PH_NORMAL;
					if (new_hex >= jsu_pkg::SURR_LO_MIN && new_hex <= jsu_pkg::SURR_LO_MAX) begin
						acc = jsu_pkg::append(acc, jsu_pkg::utf8_piece(jsu_pkg::REPL_CP));
					end else begin
						acc = jsu_pkg::append(acc, jsu_pkg::utf8_piece({5'h00, new_hex}));
					end
				end
			end
			TAIL_CP: begin
				nxt.phase = jsu_pkg::PH_NORMAL;
				acc = jsu_pkg::append(acc, jsu_pkg::utf8_piece(tail_cp));
			end
			default: ;
		endcase

		// Close the value at a quote, or flush a pending escape at message end
		if (closed_now) begin
			finish = 1'b1;
		end else if (msg_end && cur.phase != jsu_pkg::PH_DONE) begin
			finish = 1'b1;
			if (nxt.phase == jsu_pkg::PH_AFTER_HI || nxt.phase == jsu_pkg::PH_AFTER_HI_BS ||
				nxt.phase == jsu_pkg::PH_LOW_HEX) begin
				acc = jsu_pkg::append(acc, jsu_pkg::utf8_piece(jsu_pkg::REPL_CP));
			end
			if (nxt.phase == jsu_pkg::PH_HEX || nxt.phase == jsu_pkg::PH_LOW_HEX) begin
				acc = jsu_pkg::append(acc,
					jsu_pkg::literal_piece(nxt.digit_count, nxt.digit_history));
			end
		end

		// Return to start after the final byte of a message
		if (msg_end) begin
			nxt = jsu_pkg::DEC_RESET;
		end
	end

	assign grp.bytes  = acc.bytes;
	assign grp.count  = acc.count;
	assign grp.finish = finish;
	assign grp.closed = closed_now;
	assign emit       = (acc.count != '0) || finish;

endmodule

// ===== hw/rtl/jsu_out_queue.sv =====
// Two-entry queue of result groups and the serializer that sends one byte per
// output transfer from the head group. Depends on jsu_pkg.
module jsu_out_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  jsu_pkg::group_t push_grp,
	output logic            full,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [7:0]      out_byte,
	output logic            has_byte,
	output logic            last,
	output logic            closed
);

	jsu_pkg::group_t                 grp_q [jsu_pkg::GRP_DEPTH];
	logic [jsu_pkg::GRP_PTR_W-1:0]   wr_ptr_q;
	logic [jsu_pkg::GRP_PTR_W-1:0]   rd_ptr_q;
	logic [jsu_pkg::GRP_CNT_W-1:0]   cnt_q;
	logic [jsu_pkg::IDX_W-1:0]       idx_q;
	jsu_pkg::group_t                 head;
	logic [jsu_pkg::IDX_W-1:0]       last_idx;
	logic                            at_end;
	logic                            xfer;
	logic                            pop;

	assign head      = grp_q[rd_ptr_q];
	assign full      = (cnt_q == jsu_pkg::GRP_CNT_W'(jsu_pkg::GRP_DEPTH));
	assign out_valid = (cnt_q != '0);
	assign has_byte  = (head.count != '0);
	assign last_idx  = has_byte ? jsu_pkg::IDX_W'(head.count - jsu_pkg::CNT_W'(1)) : '0;
	assign at_end    = (idx_q == last_idx);
	assign out_byte  = has_byte ? head.bytes[idx_q] : 8'h00;
	assign last      = head.finish && at_end;
	assign closed    = head.finish && at_end && head.closed;
	assign xfer      = out_valid && out_ready;
	assign pop       = xfer && at_end;

	// Store pushed groups
	always_ff @(posedge clk) begin
		if (push) begin
			grp_q[wr_ptr_q] <= push_grp;
		end
	end

	// Advance pointers, fill count and the byte index within the head group
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
			idx_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == jsu_pkg::GRP_PTR_W'(jsu_pkg::GRP_DEPTH - 1)) ?
					'0 : wr_ptr_q + jsu_pkg::GRP_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == jsu_pkg::GRP_PTR_W'(jsu_pkg::GRP_DEPTH - 1)) ?
					'0 : rd_ptr_q + jsu_pkg::GRP_PTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + jsu_pkg::GRP_CNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - jsu_pkg::GRP_CNT_W'(1);
			end
			if (pop) begin
				idx_q <= '0;
			end else if (xfer) begin
				idx_q <= idx_q + jsu_pkg::IDX_W'(1);
			end
		end
	end

endmodule

// ===== hw/rtl/json_string_unescape_utf8.sv =====
// JSON string unescaper to UTF-8: input register, decoder, result group queue.
// Each item waits in the input register until the queue is not full; then its result
// group, if any, is pushed into the queue and offered from the head of the queue.
// Throughput: one item per cycle while items give at most one result each and out_ready
// stays high; an item giving n results sends them one byte per output transfer.
// The queue holds two groups. Reset (arst_n low) empties everything, normal text phase.
// Depends on jsu_pkg, jsu_decode and jsu_out_queue.
module json_string_unescape_utf8 (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       message_end,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       has_byte,
	output logic       last,
	output logic       closed
);

	logic                valid_s1;
	logic [7:0]          byte_s1;
	logic                end_s1;
	jsu_pkg::dec_state_t st_q;
	jsu_pkg::dec_state_t st_nxt;
	jsu_pkg::group_t     grp;
	logic                emit;
	logic                full;
	logic                adv;

	assign adv      = valid_s1 && !full;
	assign in_ready = !valid_s1 || !full;

	// Hold the input item in the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= in_byte;
			end_s1  <= message_end;
		end
	end

	// Advance decoder state as the item moves into the queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= jsu_pkg::DEC_RESET;
		end else if (adv) begin
			st_q <= st_nxt;
		end
	end

	jsu_decode u_decode (
		.cur     (st_q),
		.data    (byte_s1),
		.msg_end (end_s1),
		.nxt     (st_nxt),
		.grp     (grp),
		.emit    (emit)
	);

	jsu_out_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (adv && emit),
		.push_grp  (grp),
		.full      (full),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_byte  (out_byte),
		.has_byte  (has_byte),
		.last      (last),
		.closed    (closed)
	);

	// A stalled input register keeps its item
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && full |=> valid_s1 && $stable(byte_s1) && $stable(end_s1))
		else $error("input register lost a stalled item");

	// Message end returns the decoder to its start state
	a_end_reset: assert property (@(posedge clk) disable iff (!arst_n)
		adv && end_s1 |=> st_q.phase == jsu_pkg::PH_NORMAL && st_q.digit_count == '0)
		else $error("decoder state not cleared after message end");

	// A bare marker is only sent together with last
	a_bare_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !has_byte |-> last)
		else $error("bare result without last");

	// Closed is only set together with last
	a_closed_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && closed |-> last)
		else $error("closed flag without last");

endmodule

// ===== bench/json_string_unescape_utf8_tb.sv =====
// Self-checking bench for json_string_unescape_utf8: directed escapes, random JSON
// string traffic with stalls on both channels, and a long output hold-off.
// Depends on jsu_pkg (phase codes, character and UTF-8 constants) and the RTL.
module json_string_unescape_utf8_tb;

	// Fragment kinds for message generation; escape kinds run from FR_SIMPLE_ESC on
	localparam int FR_PLAIN        = 0;
	localparam int FR_RAW          = 1;
	localparam int FR_SIMPLE_ESC   = 2;
	localparam int FR_ODD_ESC      = 3;
	localparam int FR_BMP          = 4;
	localparam int FR_PAIR         = 5;
	localparam int FR_LONE_HIGH    = 6;
	localparam int FR_HIGH_BAD_LOW = 7;
	localparam int FR_HIGH_ESC     = 8;
	localparam int FR_LONE_LOW     = 9;
	localparam int FR_BAD_HEX      = 10;
	localparam int FR_HIGH_BAD_HEX = 11;
	localparam int FR_LAST         = FR_HIGH_BAD_HEX;

	localparam int RUN_LIMIT_CYCLES = 500000;
	localparam int MAX_REPORTS      = 20;

	typedef struct packed {
		logic [7:0] data;
		logic       has_data;
		logic       fin;
		logic       cls;
	} result_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] in_byte = 8'h00;
	logic       message_end = 1'b0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [7:0] out_byte;
	logic       has_byte;
	logic       last;
	logic       closed;

	// Decoder state mirror
	jsu_pkg::phase_t dec_phase = jsu_pkg::PH_NORMAL;
	logic [15:0]     dec_hex = 16'h0;
	logic [2:0]      dec_ndig = 3'h0;
	logic [23:0]     dec_hist = 24'h0;
	logic [15:0]     dec_hi = 16'h0;
	logic [7:0]      step_bytes[$];
	logic            step_closed;

	result_t     expected_results[$];
	logic [7:0]  msg_bytes[$];

	int send_gap_pct = 0;
	int recv_gap_pct = 0;
	int hold_request = 0;
	int hold_left = 0;
	int err_count = 0;
	int decoded_bytes = 0;
	int items_sent = 0;
	int messages_sent = 0;
	int results_checked = 0;
	int closed_values = 0;

	json_string_unescape_utf8 dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_byte(in_byte),
		.message_end(message_end),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_byte(out_byte),
		.has_byte(has_byte),
		.last(last),
		.closed(closed)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// ---------------------------------------------------------------- decoder model

	function automatic int hex_nibble(input logic [7:0] c);
		if (c >= jsu_pkg::CH_0 && c <= jsu_pkg::CH_9) begin
			return int'(c - jsu_pkg::CH_0);
		end
		if (c >= jsu_pkg::CH_LA && c <= jsu_pkg::CH_LF) begin
			return int'(c - jsu_pkg::CH_LA) + 10;
		end
		if (c >= jsu_pkg::CH_UA && c <= jsu_pkg::CH_UF) begin
			return int'(c - jsu_pkg::CH_UA) + 10;
		end
		return -1;
	endfunction

	// Drop bytes beyond the per-item limit
	function automatic void emit_byte(input logic [7:0] b);
		if (step_bytes.size() < jsu_pkg::MAX_OUT) begin
			step_bytes = {step_bytes, b};
		end
	endfunction

	function automatic void emit_cp(input logic [20:0] cp);
		if (cp < 21'h80) begin
			emit_byte({1'b0, cp[6:0]});
		end else if (cp < 21'h800) begin
			emit_byte(jsu_pkg::UTF8_LEAD2 | {3'b000, cp[10:6]});
			emit_byte(jsu_pkg::UTF8_CONT | {2'b00, cp[5:0]});
		end else if (cp < jsu_pkg::SUPP_BASE) begin
			emit_byte(jsu_pkg::UTF8_LEAD3 | {4'h0, cp[15:12]});
			emit_byte(jsu_pkg::UTF8_CONT | {2'b00, cp[11:6]});
			emit_byte(jsu_pkg::UTF8_CONT | {2'b00, cp[5:0]});
		end else begin
			emit_byte(jsu_pkg::UTF8_LEAD4 | {5'h00, cp[20:18]});
			emit_byte(jsu_pkg::UTF8_CONT | {2'b00, cp[17:12]});
			emit_byte(jsu_pkg::UTF8_CONT | {2'b00, cp[11:6]});
			emit_byte(jsu_pkg::UTF8_CONT | {2'b00, cp[5:0]});
		end
	endfunction

	// Replay a broken \u: backslash, 'u' and at most three stored digits
	function automatic void emit_literal_u();
		int n;
		int i;
		n = (dec_ndig > 3'd3) ? 3 : int'(dec_ndig);
		emit_byte(jsu_pkg::CH_BSLASH);
		emit_byte(jsu_pkg::CH_LU);
		for (i = 0; i < n; i++) begin
			emit_byte(dec_hist[8*i +: 8]);
		end
	endfunction

	function automatic void open_digits(input jsu_pkg::phase_t ph);
		dec_phase = ph;
		dec_hex = 16'h0;
		dec_ndig = 3'h0;
		dec_hist = 24'h0;
	endfunction

	function automatic void text_char(input logic [7:0] c);
		dec_phase = jsu_pkg::PH_NORMAL;
		if (c == jsu_pkg::CH_QUOTE) begin
			dec_phase = jsu_pkg::PH_DONE;
			step_closed = 1'b1;
		end else if (c == jsu_pkg::CH_BSLASH) begin
			dec_phase = jsu_pkg::PH_ESC;
		end else begin
			emit_byte(c);
		end
	endfunction

	function automatic void escaped_char(input logic [7:0] c);
		dec_phase = jsu_pkg::PH_NORMAL;
		case (c)
			jsu_pkg::CH_QUOTE:  emit_byte(jsu_pkg::CH_QUOTE);
			jsu_pkg::CH_BSLASH: emit_byte(jsu_pkg::CH_BSLASH);
			jsu_pkg::CH_SLASH:  emit_byte(jsu_pkg::CH_SLASH);
			jsu_pkg::CH_LB:     emit_byte(jsu_pkg::CTL_BS);
			jsu_pkg::CH_LF:     emit_byte(jsu_pkg::CTL_FF);
			jsu_pkg::CH_LN:     emit_byte(jsu_pkg::CTL_LF);
			jsu_pkg::CH_LR:     emit_byte(jsu_pkg::CTL_CR);
			jsu_pkg::CH_LT:     emit_byte(jsu_pkg::CTL_TAB);
			jsu_pkg::CH_LU:     open_digits(jsu_pkg::PH_HEX);
			default: begin
				emit_byte(jsu_pkg::CH_BSLASH);
				emit_byte(c);
			end
		endcase
	endfunction

	// Hold a high surrogate, replace a lone low one, encode anything else
	function automatic void first_cp(input logic [15:0] cp);
		if (cp >= jsu_pkg::SURR_HI_MIN && cp <= jsu_pkg::SURR_HI_MAX) begin
			dec_hi = cp;
			dec_phase = jsu_pkg::PH_AFTER_HI;
		end else begin
			if (cp >= jsu_pkg::SURR_LO_MIN && cp <= jsu_pkg::SURR_LO_MAX) begin
				emit_cp(jsu_pkg::REPL_CP);
			end else begin
				emit_cp({5'h00, cp});
			end
			dec_phase = jsu_pkg::PH_NORMAL;
		end
	endfunction

	// Advance the model by one accepted byte and queue the results it causes
	function automatic void predict_item(input logic [7:0] c, input logic at_end);
		logic        was_done;
		logic        finish;
		int          nib;
		int          i;
		logic [15:0] hi_off;
		logic [15:0] lo_off;
		result_t     r;
		was_done = (dec_phase == jsu_pkg::PH_DONE);
		if (!was_done) begin
			decoded_bytes++;
		end
		step_bytes.delete();
		step_closed = 1'b0;
		case (dec_phase)
			jsu_pkg::PH_ESC: escaped_char(c);
			jsu_pkg::PH_HEX, jsu_pkg::PH_LOW_HEX: begin
				nib = hex_nibble(c);
				if (nib >= 0 && dec_ndig < 3'd4) begin
					if (dec_ndig < 3'd3) begin
						dec_hist[8*dec_ndig +: 8] = c;
					end
					dec_hex = {dec_hex[11:0], nib[3:0]};
					dec_ndig = dec_ndig + 3'd1;
					if (dec_ndig == 3'd4) begin
						if (dec_phase == jsu_pkg::PH_HEX) begin
							first_cp(dec_hex);
						end else if (dec_hex >= jsu_pkg::SURR_LO_MIN &&
							dec_hex <= jsu_pkg::SURR_LO_MAX) begin
							hi_off = dec_hi - jsu_pkg::SURR_HI_MIN;
							lo_off = dec_hex - jsu_pkg::SURR_LO_MIN;
							emit_cp(jsu_pkg::SUPP_BASE + {1'b0, hi_off[9:0], 10'h000} +
								{11'h000, lo_off[9:0]});
							dec_phase = jsu_pkg::PH_NORMAL;
						end else begin
							emit_cp(jsu_pkg::REPL_CP);
							first_cp(dec_hex);
						end
					end
				end else begin
					if (dec_phase == jsu_pkg::PH_LOW_HEX) begin
						emit_cp(jsu_pkg::REPL_CP);
					end
					emit_literal_u();
					text_char(c);
				end
			end
			jsu_pkg::PH_AFTER_HI: begin
				if (c == jsu_pkg::CH_BSLASH) begin
					dec_phase = jsu_pkg::PH_AFTER_HI_BS;
				end else begin
					emit_cp(jsu_pkg::REPL_CP);
					text_char(c);
				end
			end
			jsu_pkg::PH_AFTER_HI_BS: begin
				if (c == jsu_pkg::CH_LU) begin
					open_digits(jsu_pkg::PH_LOW_HEX);
				end else begin
					emit_cp(jsu_pkg::REPL_CP);
					escaped_char(c);
				end
			end
			jsu_pkg::PH_DONE: ;
			default: text_char(c);
		endcase
		finish = step_closed || (at_end && !was_done);
		// flush an escape cut short by the message end
		if (at_end && !was_done && !step_closed) begin
			case (dec_phase)
				jsu_pkg::PH_HEX: emit_literal_u();
				jsu_pkg::PH_AFTER_HI, jsu_pkg::PH_AFTER_HI_BS: emit_cp(jsu_pkg::REPL_CP);
				jsu_pkg::PH_LOW_HEX: begin
					emit_cp(jsu_pkg::REPL_CP);
					emit_literal_u();
				end
				default: ;
			endcase
		end
		if (at_end) begin
			dec_phase = jsu_pkg::PH_NORMAL;
			dec_hex = 16'h0;
			dec_ndig = 3'h0;
			dec_hist = 24'h0;
			dec_hi = 16'h0;
			messages_sent++;
		end
		for (i = 0; i < step_bytes.size(); i++) begin
			r.data = step_bytes[i];
			r.has_data = 1'b1;
			r.fin = finish && (i == step_bytes.size() - 1);
			r.cls = r.fin && step_closed;
			expected_results = {expected_results, r};
		end
		// bare end marker when the ending byte decoded to nothing
		if (finish && step_bytes.size() == 0) begin
			r.data = 8'h00;
			r.has_data = 1'b0;
			r.fin = 1'b1;
			r.cls = step_closed;
			expected_results = {expected_results, r};
		end
	endfunction

	// ---------------------------------------------------------------- message generation

	// Append one byte to the message under construction
	function automatic void add_msg_byte(input logic [7:0] b);
		msg_bytes = {msg_bytes, b};
	endfunction

	function automatic logic [7:0] esc_letter(input int k);
		case (k)
			0: return jsu_pkg::CH_QUOTE;
			1: return jsu_pkg::CH_BSLASH;
			2: return jsu_pkg::CH_SLASH;
			3: return jsu_pkg::CH_LB;
			4: return jsu_pkg::CH_LF;
			5: return jsu_pkg::CH_LN;
			6: return jsu_pkg::CH_LR;
			7: return jsu_pkg::CH_LT;
			default: return jsu_pkg::CH_LU;
		endcase
	endfunction

	function automatic logic [7:0] odd_escape_char();
		logic [7:0] c;
		logic       known;
		int         k;
		known = 1'b1;
		c = 8'h00;
		while (known) begin
			c = 8'($urandom_range(255));
			known = 1'b0;
			for (k = 0; k < 9; k++) begin
				if (c == esc_letter(k)) begin
					known = 1'b1;
				end
			end
		end
		return c;
	endfunction

	function automatic logic [7:0] plain_char();
		logic [7:0] c;
		c = jsu_pkg::CH_QUOTE;
		while (c == jsu_pkg::CH_QUOTE || c == jsu_pkg::CH_BSLASH) begin
			c = 8'($urandom_range(8'h7E, 8'h20));
		end
		return c;
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] n);
		if (n < 4'd10) begin
			return jsu_pkg::CH_0 + {4'h0, n};
		end
		if ($urandom_range(1) == 0) begin
			return jsu_pkg::CH_LA + {4'h0, n} - 8'd10;
		end
		return jsu_pkg::CH_UA + {4'h0, n} - 8'd10;
	endfunction

	// Favor the ends of each code point range
	function automatic logic [15:0] pick_in(input int lo, input int hi);
		case ($urandom_range(7))
			0: return 16'(lo);
			1: return 16'(hi);
			default: return 16'($urandom_range(hi, lo));
		endcase
	endfunction

	function automatic logic [15:0] pick_bmp();
		case ($urandom_range(3))
			0: return pick_in(16'h0000, 16'h007F);
			1: return pick_in(16'h0080, 16'h07FF);
			2: return pick_in(16'h0800, 16'hD7FF);
			default: return pick_in(16'hE000, 16'hFFFF);
		endcase
	endfunction

	function automatic void put_u_escape(input logic [15:0] v);
		int i;
		add_msg_byte(jsu_pkg::CH_BSLASH);
		add_msg_byte(jsu_pkg::CH_LU);
		for (i = 3; i >= 0; i--) begin
			add_msg_byte(hex_char(v[4*i +: 4]));
		end
	endfunction

	// \u with fewer than four digits, broken by a non-hex byte
	function automatic void put_bad_u();
		logic [7:0] c;
		add_msg_byte(jsu_pkg::CH_BSLASH);
		add_msg_byte(jsu_pkg::CH_LU);
		repeat ($urandom_range(3)) add_msg_byte(hex_char(4'($urandom_range(15))));
		c = jsu_pkg::CH_0;
		while (hex_nibble(c) >= 0 || c == jsu_pkg::CH_QUOTE) begin
			c = 8'($urandom_range(255));
		end
		add_msg_byte(c);
	endfunction

	function automatic void add_fragment(input int kind);
		logic [7:0] c;
		int         k;
		case (kind)
			FR_PLAIN: add_msg_byte(plain_char());
			FR_RAW: begin
				c = jsu_pkg::CH_QUOTE;
				while (c == jsu_pkg::CH_QUOTE || c == jsu_pkg::CH_BSLASH) begin
					c = 8'($urandom_range(255));
				end
				add_msg_byte(c);
			end
			FR_SIMPLE_ESC: begin
				add_msg_byte(jsu_pkg::CH_BSLASH);
				add_msg_byte(esc_letter($urandom_range(7)));
			end
			FR_ODD_ESC: begin
				add_msg_byte(jsu_pkg::CH_BSLASH);
				add_msg_byte(odd_escape_char());
			end
			FR_BMP: put_u_escape(pick_bmp());
			FR_PAIR: begin
				put_u_escape(pick_in(jsu_pkg::SURR_HI_MIN, jsu_pkg::SURR_HI_MAX));
				put_u_escape(pick_in(jsu_pkg::SURR_LO_MIN, jsu_pkg::SURR_LO_MAX));
			end
			FR_LONE_HIGH: begin
				put_u_escape(pick_in(jsu_pkg::SURR_HI_MIN, jsu_pkg::SURR_HI_MAX));
				add_msg_byte(plain_char());
			end
			FR_HIGH_BAD_LOW: begin
				put_u_escape(pick_in(jsu_pkg::SURR_HI_MIN, jsu_pkg::SURR_HI_MAX));
				if ($urandom_range(1) == 0) begin
					put_u_escape(pick_bmp());
				end else begin
					put_u_escape(pick_in(jsu_pkg::SURR_HI_MIN, jsu_pkg::SURR_HI_MAX));
				end
			end
			FR_HIGH_ESC: begin
				put_u_escape(pick_in(jsu_pkg::SURR_HI_MIN, jsu_pkg::SURR_HI_MAX));
				add_msg_byte(jsu_pkg::CH_BSLASH);
				k = $urandom_range(8);
				add_msg_byte((k == 8) ? odd_escape_char() : esc_letter(k));
			end
			FR_LONE_LOW: put_u_escape(pick_in(jsu_pkg::SURR_LO_MIN, jsu_pkg::SURR_LO_MAX));
			FR_BAD_HEX: put_bad_u();
			default: begin
				put_u_escape(pick_in(jsu_pkg::SURR_HI_MIN, jsu_pkg::SURR_HI_MAX));
				put_bad_u();
			end
		endcase
	endfunction

	// Mostly well-formed values, some cut inside an escape, some pure noise
	function automatic void build_message();
		int mark;
		int keep;
		msg_bytes.delete();
		if ($urandom_range(7) == 0) begin
			repeat ($urandom_range(8, 1)) begin
				case ($urandom_range(7))
					0: add_msg_byte(jsu_pkg::CH_QUOTE);
					1: add_msg_byte(jsu_pkg::CH_BSLASH);
					2: add_msg_byte(jsu_pkg::CH_LU);
					3: add_msg_byte(hex_char(4'($urandom_range(15))));
					default: add_msg_byte(8'($urandom_range(255)));
				endcase
			end
		end else begin
			repeat ($urandom_range(6)) add_fragment($urandom_range(FR_LAST));
			case ($urandom_range(9))
				0, 1, 2, 3, 4, 5: begin
					add_msg_byte(jsu_pkg::CH_QUOTE);
					repeat ($urandom_range(3)) add_msg_byte(8'($urandom_range(255)));
				end
				6, 7: ;
				default: begin
					mark = msg_bytes.size();
					add_fragment($urandom_range(FR_LAST, FR_SIMPLE_ESC));
					keep = mark + $urandom_range(msg_bytes.size() - mark - 1, 1);
					while (msg_bytes.size() > keep) begin
						void'(msg_bytes.pop_back());
					end
				end
			endcase
		end
		if (msg_bytes.size() == 0) begin
			add_msg_byte(plain_char());
		end
	endfunction

	// ---------------------------------------------------------------- channel drivers

	// Offer one byte, idling first at random; valid stays up for a following transfer
	task automatic send_byte(input logic [7:0] b, input logic at_end);
		if ($urandom_range(99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < send_gap_pct) begin
				@(posedge clk);
			end
		end
		in_valid <= 1'b1;
		in_byte <= b;
		message_end <= at_end;
		@(posedge clk);
		while (!in_ready) begin
			@(posedge clk);
		end
		items_sent++;
		predict_item(b, at_end);
	endtask

	task automatic send_message();
		int i;
		for (i = 0; i < msg_bytes.size(); i++) begin
			send_byte(msg_bytes[i], i == msg_bytes.size() - 1);
		end
	endtask

	// Stop offering and wait for every pending result
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_results.size() != 0) begin
			@(posedge clk);
		end
	endtask

	task automatic report_mismatch(input string what, input logic [7:0] want,
		input logic [7:0] got);
		if (err_count < MAX_REPORTS) begin
			$display("[%0t] result %0d: %s expected %0h got %0h", $time, results_checked,
				what, want, got);
		end
		err_count++;
	endtask

	// Check each output transfer, then drive ready with random or held-off stalls
	always @(posedge clk) begin : result_check
		result_t want;
		if (arst_n && out_valid && out_ready) begin
			results_checked++;
			if (expected_results.size() == 0) begin
				report_mismatch("unexpected result, out_byte", 8'h00, out_byte);
			end else begin
				want = expected_results.pop_front();
				if (out_byte !== want.data) begin
					report_mismatch("out_byte", want.data, out_byte);
				end
				if (has_byte !== want.has_data) begin
					report_mismatch("has_byte", {7'h0, want.has_data}, {7'h0, has_byte});
				end
				if (last !== want.fin) begin
					report_mismatch("last", {7'h0, want.fin}, {7'h0, last});
				end
				if (closed !== want.cls) begin
					report_mismatch("closed", {7'h0, want.cls}, {7'h0, closed});
				end
				if (want.fin && want.cls) begin
					closed_values++;
				end
			end
		end
		if (hold_request > 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_gap_pct);
		end
	end

	// ---------------------------------------------------------------- tests

	// Byte extremes, every single-character escape letter but u, an unknown escape, bytes after the quote,
	// and a message that ends on a lone backslash
	task automatic test_directed();
		int k;
		send_gap_pct = 32;
		recv_gap_pct = 56;
		msg_bytes.delete();
		add_msg_byte(8'h00);
		add_msg_byte(8'hFF);
		for (k = 0; k < 8; k++) begin
			add_msg_byte(jsu_pkg::CH_BSLASH);
			add_msg_byte(esc_letter(k));
		end
		add_msg_byte(jsu_pkg::CH_BSLASH);
		add_msg_byte("q");
		add_msg_byte(jsu_pkg::CH_QUOTE);
		add_msg_byte("z");
		send_message();
		msg_bytes.delete();
		add_msg_byte(jsu_pkg::CH_BSLASH);
		send_message();
		wait_drained();
	endtask

	task automatic test_random_traffic(input int snd_gap, input int rcv_gap, input int goal);
		int goal_end;
		send_gap_pct = snd_gap;
		recv_gap_pct = rcv_gap;
		goal_end = items_sent + goal;
		while (items_sent < goal_end) begin
			build_message();
			send_message();
		end
		wait_drained();
	endtask

	// Hold the output off long enough to fill the block while bytes keep coming
	task automatic test_backpressure();
		int i;
		send_gap_pct = 0;
		recv_gap_pct = 0;
		msg_bytes.delete();
		for (i = 0; i < 8; i++) begin
			add_fragment((i % 2 == 0) ? FR_PAIR : FR_BMP);
		end
		hold_request = 150;
		send_message();
		wait_drained();
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_random_traffic(32, 56, 85);
		test_random_traffic(56, 32, 85);
		test_backpressure();
		test_random_traffic(0, 0, 85);
		repeat (16) @(posedge clk);
		$display("Sent %0d bytes (%0d decoded) in %0d messages; %0d output transfers checked,",
			items_sent, decoded_bytes, messages_sent, results_checked);
		$display("%0d values closed by a quote. Escapes, surrogates, truncation and stalls.",
			closed_values);
		if (err_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	initial begin
		#(RUN_LIMIT_CYCLES * 20);
		$display("TB_ERROR");
		$finish;
	end

endmodule

// ===== filelist.f =====
hw/rtl/jsu_pkg.sv
hw/rtl/jsu_decode.sv
hw/rtl/jsu_out_queue.sv
hw/rtl/json_string_unescape_utf8.sv
bench/json_string_unescape_utf8_tb.sv
